### hdl/sidba_pkg.sv
`timescale 1ns / 1ps
// Types and constants shared by the station identifier allocator.
package sidba_pkg;

  localparam int unsigned SlotW = 5;
  localparam int unsigned IdW = 11;
  localparam int unsigned BitW = 5;
  localparam int unsigned WordBits = 32;

  typedef enum logic [1:0] {
    StNew  = 2'd0,
    StHeld = 2'd1,
    StNone = 2'd2
  } alloc_status_e;

  typedef enum logic [1:0] {
    SIdle,
    SSlotRd,
    SScan,
    SResult
  } seq_state_e;

endpackage

### hdl/station_id_bitmap_allocator_unit.sv
`timescale 1ns / 1ps
// Station identifier allocator: first-fit bitmap scan with a per-slot identifier table.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o   | station_slot_i
//  out     | output    | out_valid_o / out_ready_i | assigned_id_o, alloc_status_o
//
// One item is handled at a time; in_ready_o is high only while the sequencer is idle.
// A slot out of range goes straight to the result state, a slot that already holds an
// identifier answers once the slot table has been read, and a scan answers once the bitmap
// word examined last has been checked, the bitmap being read one word per cycle.
// Reset clears the sequencer and the valid bits of both stores; there is no clearing pass.
// The result is held in output registers until out_ready_i takes it.
module station_id_bitmap_allocator_unit #(
  parameter int unsigned ID_LIMIT = 2007,
  parameter int unsigned SLOT_COUNT = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [sidba_pkg::SlotW-1:0]   station_slot_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sidba_pkg::IdW-1:0]     assigned_id_o,
  output logic [1:0]                    alloc_status_o
);
  import sidba_pkg::*;

  localparam int unsigned WordCount = (ID_LIMIT + WordBits) / WordBits;
  localparam int unsigned WAw = $clog2(WordCount);
  localparam int unsigned SlotAw = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  seq_state_e state_q, state_d;

  logic [SlotAw-1:0] slot_q, slot_d;
  logic [WAw-1:0] ptr_q, ptr_d;
  logic [IdW-1:0] id_q, id_d;
  alloc_status_e status_q, status_d;

  logic [IdW-1:0] slot_mem [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] slot_vld_q;
  logic [IdW-1:0] sl_rdata_q;
  logic sl_rvld_q;
  logic [SlotAw-1:0] sl_raddr;
  logic sl_we;

  logic [WordBits-1:0] bm_mem [WordCount];
  logic [WordCount-1:0] word_vld_q;
  logic [WordBits-1:0] bm_rdata_q;
  logic bm_rvld_q;
  logic [WAw-1:0] bm_raddr;
  logic bm_we;
  logic [WordBits-1:0] bm_wdata;

  logic [8:0] slot_ext;
  logic slot_in_range;
  logic [WordBits-1:0] word_cur;
  logic [WordBits-1:0] free_bits;
  logic [WordBits-1:0] first_free;
  logic [BitW-1:0] bit_idx;
  logic [IdW:0] cand_id;
  logic word_full;

  assign slot_ext = {4'b0000, station_slot_i};
  assign slot_in_range = (slot_ext < 9'(SLOT_COUNT));
  assign sl_raddr = slot_ext[SlotAw-1:0];

  assign word_cur = bm_rvld_q ? bm_rdata_q : '0;
  assign word_full = &word_cur;
  assign free_bits = ~word_cur;
  assign first_free = free_bits & (~free_bits + 1'b1);

  always_comb begin
    bit_idx = '0;
    for (int k = 0; k < int'(BitW); k++) begin
      for (int i = 0; i < int'(WordBits); i++) begin
        if (((i >> k) & 1) == 1) begin
          bit_idx[k] = bit_idx[k] | first_free[i];
        end
      end
    end
  end

  assign cand_id = (IdW + 1)'({ptr_q, bit_idx}) + 1'b1;
  assign bm_wdata = word_cur | first_free;

  always_ff @(posedge clk_i) begin
    sl_rdata_q <= slot_mem[sl_raddr];
    if (sl_we) begin
      slot_mem[slot_q] <= cand_id[IdW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    bm_rdata_q <= bm_mem[bm_raddr];
    if (bm_we) begin
      bm_mem[ptr_q] <= bm_wdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_vld_q <= '0;
      word_vld_q <= '0;
      sl_rvld_q <= 1'b0;
      bm_rvld_q <= 1'b0;
    end else begin
      sl_rvld_q <= slot_vld_q[sl_raddr];
      bm_rvld_q <= word_vld_q[bm_raddr];
      if (sl_we) begin
        slot_vld_q[slot_q] <= 1'b1;
      end
      if (bm_we) begin
        word_vld_q[ptr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    ptr_q <= ptr_d;
    id_q <= id_d;
    status_q <= status_d;
  end

  always_comb begin
    state_d = state_q;
    slot_d = slot_q;
    ptr_d = ptr_q;
    id_d = id_q;
    status_d = status_q;
    bm_raddr = ptr_q;
    sl_we = 1'b0;
    bm_we = 1'b0;
    in_ready_o = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      SIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          slot_d = sl_raddr;
          if (slot_in_range) begin
            state_d = SSlotRd;
          end else begin
            id_d = '0;
            status_d = StNone;
            state_d = SResult;
          end
        end
      end
      SSlotRd: begin
        bm_raddr = '0;
        ptr_d = '0;
        if (sl_rvld_q) begin
          id_d = sl_rdata_q;
          status_d = StHeld;
          state_d = SResult;
        end else begin
          state_d = SScan;
        end
      end
      SScan: begin
        if (word_full) begin
          if (ptr_q == WAw'(WordCount - 1)) begin
            id_d = '0;
            status_d = StNone;
            state_d = SResult;
          end else begin
            ptr_d = ptr_q + 1'b1;
            bm_raddr = ptr_q + 1'b1;
          end
        end else if (cand_id > (IdW + 1)'(ID_LIMIT)) begin
          id_d = '0;
          status_d = StNone;
          state_d = SResult;
        end else begin
          bm_we = 1'b1;
          sl_we = 1'b1;
          id_d = cand_id[IdW-1:0];
          status_d = StNew;
          state_d = SResult;
        end
      end
      SResult: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign assigned_id_o = id_q;
  assign alloc_status_o = status_q;

endmodule

### sim/station_id_bitmap_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the station identifier allocator, with bursty requests and a stalling receiver.
module station_id_bitmap_allocator_unit_tb;
  import sidba_pkg::*;

  localparam int unsigned SlotLimit = 32;
  localparam int unsigned IdLimit = 2007;
  localparam int unsigned WordCount = (IdLimit + 1 + 31) / 32;
  localparam int unsigned RandomItems = 1550;

  class id_grant_scoreboard;
    logic [WordBits-1:0] id_map[WordCount];
    logic [IdW-1:0] held_id[SlotLimit];
    logic [IdW-1:0] want_id[$];
    alloc_status_e want_status[$];
    int unsigned errors;

    function new();
      foreach (id_map[w]) id_map[w] = '0;
      foreach (held_id[s]) held_id[s] = '0;
      errors = 0;
    endfunction

    function void queue_grant(logic [IdW-1:0] id, alloc_status_e status);
      want_id.push_back(id);
      want_status.push_back(status);
    endfunction

    function void note_request(logic [SlotW-1:0] slot);
      int unsigned w;
      int unsigned b;
      int unsigned id;
      bit found;
      found = 1'b0;
      b = 0;
      if (slot >= SlotLimit) begin
        queue_grant('0, StNone);
        return;
      end
      if (held_id[slot] != '0) begin
        queue_grant(held_id[slot], StHeld);
        return;
      end
      for (w = 0; w < WordCount; w++) begin
        if (id_map[w] != '1) begin
          for (b = 0; b < WordBits; b++) begin
            if (!id_map[w][b]) break;
          end
          found = 1'b1;
          break;
        end
      end
      id = w * WordBits + b + 1;
      if (!found || id > IdLimit) begin
        queue_grant('0, StNone);
      end else begin
        id_map[w][b] = 1'b1;
        held_id[slot] = id[IdW-1:0];
        queue_grant(id[IdW-1:0], StNew);
      end
    endfunction

    function void check_answer(logic [IdW-1:0] id, logic [1:0] status);
      logic [IdW-1:0] exp_id;
      alloc_status_e exp_status;
      if (want_id.size() == 0) begin
        $error("Unexpected item: assigned_id %0d, alloc_status %0d.", id, status);
        errors++;
        return;
      end
      exp_id = want_id.pop_front();
      exp_status = want_status.pop_front();
      if (id !== exp_id) begin
        $error("assigned_id: expected %0d, actual %0d.", exp_id, id);
        errors++;
      end
      if (status !== exp_status) begin
        $error("alloc_status: expected %s (%0d), actual %0d.", exp_status.name(), exp_status,
               status);
        errors++;
      end
    endfunction

    function int unsigned outstanding();
      return want_id.size();
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  logic [SlotW-1:0] station_slot_i;
  logic out_valid_o;
  logic out_ready_i;
  logic [IdW-1:0] assigned_id_o;
  logic [1:0] alloc_status_o;

  id_grant_scoreboard board = new();
  int unsigned burst_left = 0;

  station_id_bitmap_allocator_unit #(
    .ID_LIMIT(IdLimit),
    .SLOT_COUNT(SlotLimit)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .station_slot_i(station_slot_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .assigned_id_o(assigned_id_o),
    .alloc_status_o(alloc_status_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic send_request(input logic [SlotW-1:0] slot);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      repeat (gap) begin
        @(negedge clk_i);
        in_valid_i = 1'b0;
      end
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    station_slot_i = slot;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_request(slot);
  endtask

  initial begin
    int unsigned run_left;
    bit stalling;
    out_ready_i = 1'b0;
    run_left = 0;
    stalling = 1'b1;
    forever begin
      @(negedge clk_i);
      if (run_left == 0) begin
        stalling = ~stalling;
        run_left = stalling ? $urandom_range(1, 20) : $urandom_range(1, 60);
      end
      out_ready_i = !stalling;
      run_left--;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      board.check_answer(assigned_id_o, alloc_status_o);
    end
  end

  initial begin
    logic [SlotW-1:0] opening[] = '{5'd0, 5'd0, 5'd27, 5'd28, 5'd31, 5'd1, 5'd2, 5'd27, 5'd30,
                                   5'd16, 5'd15, 5'd21, 5'd10, 5'd29, 5'd3, 5'd2, 5'd31};
    int unsigned waited;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    station_slot_i = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (opening[k]) send_request(opening[k]);
    repeat (RandomItems) send_request(5'($urandom_range(0, 31)));

    @(negedge clk_i);
    in_valid_i = 1'b0;
    waited = 0;
    while (board.outstanding() != 0 && waited < 100000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (80) @(posedge clk_i);
    if (board.outstanding() != 0) begin
      $error("%0d expected items never arrived.", board.outstanding());
      board.errors++;
    end
    if (board.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

### files.f
hdl/sidba_pkg.sv
hdl/station_id_bitmap_allocator_unit.sv
sim/station_id_bitmap_allocator_unit_tb.sv
